// ===== rtl/ecu_pkg.sv =====
// Package for the emulated console UART: request and response structs,
// function codes, status byte masks and FIFO control types.
// Depends on nothing; every other file imports it.
package ecu_pkg;

   localparam logic [2:0] FUNC_TICK       = 3'd0;
   localparam logic [2:0] FUNC_HOST_SEND  = 3'd1;
   localparam logic [2:0] FUNC_HOST_RECV  = 3'd2;
   localparam logic [2:0] FUNC_GUEST_SEND = 3'd3;
   localparam logic [2:0] FUNC_GUEST_RECV = 3'd4;
   localparam logic [2:0] FUNC_GUEST_CTRL = 3'd5;

   localparam logic [7:0] ST_TX_IRQ   = 8'h80;
   localparam logic [7:0] ST_TX_AVAIL = 8'h40;
   localparam logic [7:0] ST_TX_ERR   = 8'h20;
   localparam logic [7:0] ST_RX_IRQ   = 8'h08;
   localparam logic [7:0] ST_RX_AVAIL = 8'h04;
   localparam logic [7:0] ST_RX_ERR   = 8'h02;
   localparam logic [7:0] ST_TX_ALL   = ST_TX_IRQ | ST_TX_AVAIL | ST_TX_ERR;
   localparam logic [7:0] ST_RX_ALL   = ST_RX_IRQ | ST_RX_AVAIL | ST_RX_ERR;
   localparam logic [7:0] ST_IRQ_ALL  = ST_TX_IRQ | ST_RX_IRQ;

   localparam int FILL_W = 5;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] data_in;
   } req_type;

   typedef struct packed {
      logic [7:0]        data_out;
      logic              data_valid;
      logic              tx_irq_enable_bit;
      logic              tx_avail_bit;
      logic              tx_error_bit;
      logic              rx_irq_enable_bit;
      logic              rx_avail_bit;
      logic              rx_error_bit;
      logic              irq_out;
      logic [FILL_W-1:0] tx_fill;
      logic [FILL_W-1:0] rx_fill;
      logic              host_can_send;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } fifo_ctl_type;

   typedef enum logic [1:0] {
      SRC_REG,
      SRC_TX,
      SRC_RX
   } data_src_type;

endpackage

// ===== rtl/ecu_fifo.sv =====
// Byte FIFO with one write port and a registered read of the head entry.
// Uses ecu_pkg for the push, pop and flush control struct.
module ecu_fifo #(
   parameter int DEPTH = 16,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ecu_pkg::fifo_ctl_type ctl,
   input  logic [7:0]           wr_data,
   output logic [CW-1:0]        count,
   output logic [CW-1:0]        count_next,
   output logic [7:0]           rd_data
);
   import ecu_pkg::*;

   localparam int PW = $clog2(DEPTH);

   logic [7:0]    mem [DEPTH];
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    rd_data_ff;

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.flush) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (ctl.push) begin
         tail_in  = wrap_inc(tail_ff);
         count_in = count_ff + 1'b1;
      end else if (ctl.pop) begin
         head_in  = wrap_inc(head_ff);
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push && !ctl.flush) begin
         mem[tail_ff] <= wr_data;
      end
      rd_data_ff <= mem[head_ff];
   end

   assign count      = count_ff;
   assign count_next = count_in;
   assign rd_data    = rd_data_ff;

endmodule

// ===== rtl/emulated_console_uart.sv =====
// A response strobe is registered and follows each accepted request in the next cycle.
// Throughput: one request per cycle; busy is high only while reset is held.
// Both FIFOs update and read their head entry at the accepting edge.
// Reset: synchronous; FIFOs empty, status clear, both FIFO resets pending.
// The receiver cannot stall, so responses are never held back.
module emulated_console_uart #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ecu_pkg::req_type req_item,
   output logic             rsp_valid,
   output ecu_pkg::rsp_type rsp_item
);
   import ecu_pkg::*;

   localparam int CW = $clog2(FIFO_DEPTH + 1);

   logic          accept;
   fifo_ctl_type  tx_ctl, rx_ctl;
   logic [CW-1:0] tx_count, rx_count, tx_count_next, rx_count_next;
   logic [7:0]    tx_rd_data, rx_rd_data;
   logic          tx_full, rx_full;

   logic [7:0]   status_ff, status_in;
   logic         pend_tx_ff, pend_tx_in;
   logic         pend_rx_ff, pend_rx_in;
   logic         irq_tx_ff, irq_tx_in;
   logic         irq_rx_ff, irq_rx_in;
   logic         rsp_valid_ff;
   rsp_type      rsp_ff, rsp_in;
   data_src_type src_ff, src_in;

   logic [7:0]  ctrl_byte;
   logic        ctrl_tx, ctrl_rx;
   logic [31:0] tx_fill_wide, rx_fill_wide;

   assign busy    = reset;
   assign accept  = start && !busy;
   assign tx_full = (tx_count == CW'(FIFO_DEPTH));
   assign rx_full = (rx_count == CW'(FIFO_DEPTH));

   ecu_fifo #(.DEPTH(FIFO_DEPTH), .CW(CW)) u_tx_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tx_ctl),
      .wr_data    (req_item.data_in),
      .count      (tx_count),
      .count_next (tx_count_next),
      .rd_data    (tx_rd_data)
   );

   ecu_fifo #(.DEPTH(FIFO_DEPTH), .CW(CW)) u_rx_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctl        (rx_ctl),
      .wr_data    (req_item.data_in),
      .count      (rx_count),
      .count_next (rx_count_next),
      .rd_data    (rx_rd_data)
   );

   always_comb begin
      ctrl_tx   = req_item.data_in[5];
      ctrl_rx   = req_item.data_in[1];
      ctrl_byte = req_item.data_in & ST_IRQ_ALL;
      if (ctrl_tx) begin
         ctrl_byte = ctrl_byte & ~ST_TX_IRQ;
      end
      if (ctrl_rx) begin
         ctrl_byte = ctrl_byte & ~ST_RX_IRQ;
      end
   end

   always_comb begin
      status_in  = status_ff;
      pend_tx_in = pend_tx_ff;
      pend_rx_in = pend_rx_ff;
      irq_tx_in  = irq_tx_ff;
      irq_rx_in  = irq_rx_ff;
      tx_ctl     = '0;
      rx_ctl     = '0;
      src_in     = SRC_REG;
      rsp_in     = '0;
      if (accept) begin
         case (req_item.func)
            FUNC_TICK: begin
               if (pend_tx_ff) begin
                  tx_ctl.flush = 1'b1;
                  status_in    = status_in & ~ST_TX_ALL;
               end
               if (pend_rx_ff) begin
                  rx_ctl.flush = 1'b1;
                  status_in    = status_in & ~ST_RX_ALL;
               end
               if ((status_in & ST_TX_ERR) == 8'h00) begin
                  status_in = status_in & ~ST_TX_AVAIL;
                  if (pend_tx_ff || !tx_full) begin
                     status_in = status_in | ST_TX_AVAIL;
                  end
               end
               if ((status_in & ST_RX_ERR) == 8'h00) begin
                  status_in = status_in & ~ST_RX_AVAIL;
                  if (!pend_rx_ff && rx_count != '0) begin
                     status_in = status_in | ST_RX_AVAIL;
                  end
               end
               irq_tx_in = ((status_in & (ST_TX_AVAIL | ST_TX_IRQ)) ==
                            (ST_TX_AVAIL | ST_TX_IRQ));
               irq_rx_in = ((status_in & (ST_RX_AVAIL | ST_RX_IRQ)) ==
                            (ST_RX_AVAIL | ST_RX_IRQ));
            end
            FUNC_HOST_SEND: begin
               rx_ctl.push = !rx_full;
            end
            FUNC_HOST_RECV: begin
               if (tx_count != '0) begin
                  tx_ctl.pop        = 1'b1;
                  rsp_in.data_valid = 1'b1;
                  src_in            = SRC_TX;
               end
            end
            FUNC_GUEST_SEND: begin
               if ((status_ff & ST_TX_AVAIL) == 8'h00 || (status_ff & ST_TX_ERR) != 8'h00
                   || tx_full) begin
                  status_in = status_ff | ST_TX_ERR;
               end else begin
                  tx_ctl.push = 1'b1;
                  status_in   = status_ff & ~(ST_TX_IRQ | ST_TX_AVAIL);
               end
            end
            FUNC_GUEST_RECV: begin
               if ((status_ff & ST_RX_AVAIL) == 8'h00 || (status_ff & ST_RX_ERR) != 8'h00) begin
                  status_in = status_ff | ST_RX_ERR;
               end else if (rx_count != '0) begin
                  rx_ctl.pop        = 1'b1;
                  rsp_in.data_valid = 1'b1;
                  src_in            = SRC_RX;
               end else begin
                  status_in = status_ff & ~ST_RX_AVAIL;
               end
            end
            FUNC_GUEST_CTRL: begin
               pend_tx_in      = ctrl_tx;
               pend_rx_in      = ctrl_rx;
               status_in       = ctrl_byte;
               rsp_in.data_out = ctrl_byte;
            end
            default: begin
            end
         endcase
      end
      tx_fill_wide = 32'(tx_count_next);
      rx_fill_wide = 32'(rx_count_next);
      rsp_in.tx_irq_enable_bit = (status_in & ST_TX_IRQ) != 8'h00;
      rsp_in.tx_avail_bit      = (status_in & ST_TX_AVAIL) != 8'h00;
      rsp_in.tx_error_bit      = (status_in & ST_TX_ERR) != 8'h00;
      rsp_in.rx_irq_enable_bit = (status_in & ST_RX_IRQ) != 8'h00;
      rsp_in.rx_avail_bit      = (status_in & ST_RX_AVAIL) != 8'h00;
      rsp_in.rx_error_bit      = (status_in & ST_RX_ERR) != 8'h00;
      rsp_in.irq_out           = irq_tx_in || irq_rx_in;
      rsp_in.tx_fill           = tx_fill_wide[FILL_W-1:0];
      rsp_in.rx_fill           = rx_fill_wide[FILL_W-1:0];
      rsp_in.host_can_send     = (rx_count_next != CW'(FIFO_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= 8'h00;
         pend_tx_ff   <= 1'b1;
         pend_rx_ff   <= 1'b1;
         irq_tx_ff    <= 1'b0;
         irq_rx_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         src_ff       <= SRC_REG;
      end else begin
         status_ff    <= status_in;
         pend_tx_ff   <= pend_tx_in;
         pend_rx_ff   <= pend_rx_in;
         irq_tx_ff    <= irq_tx_in;
         irq_rx_ff    <= irq_rx_in;
         rsp_valid_ff <= accept;
         src_ff       <= src_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_comb begin
      rsp_item = rsp_ff;
      case (src_ff)
         SRC_TX:  rsp_item.data_out = tx_rd_data;
         SRC_RX:  rsp_item.data_out = rx_rd_data;
         default: rsp_item.data_out = rsp_ff.data_out;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_rsp_follows_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept))
      else $error("Response strobe without an accepted request.");

   a_tx_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      tx_ctl.pop |-> (tx_count != '0 && !tx_ctl.push && !tx_ctl.flush))
      else $error("Transmit FIFO popped while empty or with another operation.");

   a_rx_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      rx_ctl.pop |-> (rx_count != '0 && !rx_ctl.push && !rx_ctl.flush))
      else $error("Receive FIFO popped while empty or with another operation.");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      (tx_count <= CW'(FIFO_DEPTH)) && (rx_count <= CW'(FIFO_DEPTH)))
      else $error("FIFO occupancy exceeds its depth.");

   a_valid_from_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.data_valid) |-> (src_ff == SRC_TX || src_ff == SRC_RX))
      else $error("Valid response data not sourced from a FIFO.");
`endif

endmodule
